[rtl/ppstd_pkg.sv]
package ppstd_pkg;

  // Event kinds carried in the input tuser bit
  typedef enum logic [0:0] {
    CMD_CAPTURE  = 1'b0,
    CMD_OVERFLOW = 1'b1
  } cmd_e;

  // Field widths
  localparam int unsigned CntW  = 32;
  localparam int unsigned RateW = 28;

  // Reset value of the clock rate register, in hertz
  localparam int unsigned RateReset = 24000000;

  // Mean deficit in cycles times this, below the clock rate, means under 500 ns
  localparam int unsigned TicksPerUnit = 1000000000 / 500;

  // Reciprocal of TicksPerUnit for an exact floor quotient of a 29-bit dividend
  localparam int unsigned  RecipShift = 51;
  localparam logic [63:0]  RecipWide  = ((64'd1 << RecipShift) + 64'(TicksPerUnit) - 64'd1)
                                        / 64'(TicksPerUnit);
  localparam int unsigned  RecipW     = 31;
  localparam logic [RecipW-1:0] Recip = RecipW'(RecipWide);

  // Threshold units for the reset clock rate: ceil(rate / TicksPerUnit)
  localparam int unsigned RateResetUnits = (RateReset + TicksPerUnit - 1) / TicksPerUnit;

  // Width of the threshold unit count (ceil of a 28-bit rate over TicksPerUnit)
  localparam int unsigned UnitW = 8;

  // One result word
  typedef struct packed {
    logic            write_load;
    logic [CntW-1:0] load_value;
    logic            trigger_reload;
    logic            start_compare;
    logic [CntW-1:0] phase_deficit;
    logic [CntW-1:0] period_estimate;
  } result_t;

endpackage

[rtl/ppstd_core.sv]
module ppstd_core #(
  parameter int unsigned AVG_LEN = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ppstd_pkg::RateW-1:0] cfg_wdata_i,
  input  logic                       step_i,
  input  ppstd_pkg::cmd_e            cmd_i,
  input  logic [ppstd_pkg::CntW-1:0] cap_i,
  input  logic                       cmp_on_i,
  output ppstd_pkg::result_t         res_o
);
  import ppstd_pkg::*;

  localparam int unsigned IdxW = $clog2(AVG_LEN);
  localparam int unsigned ThrW = UnitW + $clog2(AVG_LEN);
  localparam int unsigned SumW = CntW + 1 + $clog2(AVG_LEN);
  localparam int unsigned XW   = RateW + 1;

  // Discipline state
  logic [CntW-1:0] period_q, period_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic            prev_valid_q, prev_valid_d;
  logic [CntW-1:0] prev_cap_q, prev_cap_d;
  logic [CntW-1:0] load_cur_q, load_cur_d;    // load entry at the ring position
  logic [CntW-1:0] load_prev_q, load_prev_d;  // load entry one behind
  logic [CntW-1:0] def_prev_q, def_prev_d;    // deficit entry one behind
  logic [CntW-1:0] def_q [AVG_LEN];
  logic            def_all;
  logic            def_one;
  logic [CntW-1:0] def_val;

  // Start threshold on the deficit sum, refreshed on each rate write
  logic [ThrW-1:0]      thr_q, thr_d;
  logic [RateW-1:0]     rate_eff;
  logic [XW-1:0]        rate_x;
  logic [XW+RecipW-1:0] rate_prod;
  logic [UnitW-1:0]     units;

  always_comb begin
    rate_eff  = (cfg_wdata_i == '0) ? RateW'(1) : cfg_wdata_i;
    rate_x    = XW'(rate_eff) + XW'(TicksPerUnit - 1);
    rate_prod = XW'(rate_x) * (XW+RecipW)'(Recip);
    units     = UnitW'(rate_prod >> RecipShift);
    thr_d     = ThrW'(units) * ThrW'(AVG_LEN);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= ThrW'(RateResetUnits * AVG_LEN);
    end else if (cfg_we_i) begin
      thr_q <= thr_d;
    end
  end

  // Sum of absolute deficits over the ring
  logic [SumW-1:0] def_sum;
  logic [CntW-1:0] mag;

  always_comb begin
    def_sum = '0;
    for (int k = 0; k < AVG_LEN; k++) begin
      mag     = def_q[k][CntW-1] ? (CntW'(0) - def_q[k]) : def_q[k];
      def_sum = def_sum + SumW'(mag);
    end
  end

  // Capture arithmetic
  logic [CntW-1:0] half_neg;
  logic [CntW-1:0] d_val;
  logic [CntW-1:0] p_meas;
  logic [CntW+1:0] avg_sum;
  logic [CntW-1:0] period_new;
  logic [CntW-1:0] load_new;
  logic [CntW-1:0] first_period;
  logic [IdxW-1:0] idx_next;

  always_comb begin
    half_neg     = CntW'(0) - (period_q >> 1);
    d_val        = (cap_i > half_neg) ? cap_i : (cap_i - load_cur_q);
    p_meas       = (CntW'(0) - load_prev_q) + d_val - def_prev_q;
    avg_sum      = {2'b00, period_q} + {1'b0, period_q, 1'b0} + {2'b00, p_meas};
    period_new   = prev_valid_q ? avg_sum[CntW+1:2] : period_q;
    load_new     = CntW'(0) - ((period_new << 1) + load_cur_q + d_val);
    first_period = cap_i - prev_cap_q;
    idx_next     = (idx_q == IdxW'(AVG_LEN - 1)) ? '0 : idx_q + IdxW'(1);
  end

  // Next state and result
  always_comb begin
    period_d     = period_q;
    idx_d        = idx_q;
    prev_valid_d = prev_valid_q;
    prev_cap_d   = prev_cap_q;
    load_cur_d   = load_cur_q;
    load_prev_d  = load_prev_q;
    def_prev_d   = def_prev_q;
    def_all      = 1'b0;
    def_one      = 1'b0;
    def_val      = d_val;

    res_o                 = '0;
    res_o.period_estimate = period_q;

    case (cmd_i)
      CMD_CAPTURE: begin
        if (prev_valid_q && (period_q == '0)) begin
          // First period found: fill the rings and ask for an immediate reload
          period_d             = first_period;
          load_cur_d           = CntW'(0) - first_period;
          load_prev_d          = CntW'(0) - first_period;
          def_prev_d           = CntW'(0) - first_period;
          def_all              = 1'b1;
          def_val              = CntW'(0) - first_period;
          prev_valid_d         = 1'b0;
          res_o.write_load     = 1'b1;
          res_o.trigger_reload = 1'b1;
          res_o.load_value     = CntW'(0) - first_period;
        end else begin
          if (period_q != '0) begin
            period_d            = period_new;
            def_one             = prev_valid_q;
            def_all             = !prev_valid_q;
            def_prev_d          = d_val;
            load_prev_d         = load_cur_q;
            load_cur_d          = load_new;
            idx_d               = idx_next;
            res_o.load_value    = load_new;
            res_o.write_load    = !d_val[CntW-1];
            res_o.phase_deficit = d_val;
          end
          prev_cap_d   = cap_i;
          prev_valid_d = 1'b1;
        end
      end
      CMD_OVERFLOW: begin
        if (period_q != '0) begin
          res_o.write_load    = 1'b1;
          res_o.load_value    = load_cur_q;
          res_o.start_compare = !cmp_on_i && (def_sum < SumW'(thr_q));
        end
      end
      default: begin
        res_o = '0;
      end
    endcase

    res_o.period_estimate = period_d;
  end

  // Hold the state between events
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q     <= '0;
      idx_q        <= '0;
      prev_valid_q <= 1'b0;
      prev_cap_q   <= '0;
      load_cur_q   <= '0;
      load_prev_q  <= '0;
      def_prev_q   <= '0;
      for (int k = 0; k < AVG_LEN; k++) begin
        def_q[k] <= '0;
      end
    end else if (step_i) begin
      period_q     <= period_d;
      idx_q        <= idx_d;
      prev_valid_q <= prev_valid_d;
      prev_cap_q   <= prev_cap_d;
      load_cur_q   <= load_cur_d;
      load_prev_q  <= load_prev_d;
      def_prev_q   <= def_prev_d;
      for (int k = 0; k < AVG_LEN; k++) begin
        if (def_all || (def_one && (idx_q == IdxW'(k)))) begin
          def_q[k] <= def_val;
        end
      end
    end
  end

endmodule

[rtl/pps_input_timer_discipline.sv]
// Channel   Dir  Fields (lowest bit up)
// s_axis    in   tuser: cmd; tdata: capture_value, compare_on, zero pad to 40 bits
// m_axis    out  tdata: write_load, load_value, trigger_reload, start_compare,
//                phase_deficit, period_estimate, zero pad to 104 bits
// cfg       in   cfg_we_i / cfg_wdata_i: clock_rate
//
// One word is accepted per cycle while m_axis does not stall; its result word is
// taken from the input register through the core into the result register.
// The rate is set by the single registered pass through the discipline core
// between the input register and the result register.
// rst_ni clears the discipline state and sets clock_rate to 24 MHz.
// A stalled m_axis fills both registers, after which s_axis_tready drops.
module pps_input_timer_discipline #(
  parameter int unsigned AVG_LEN = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [ppstd_pkg::RateW-1:0] cfg_wdata_i,  // clock_rate
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [39:0]                s_axis_tdata,  // capture_value, compare_on
  input  logic [0:0]                 s_axis_tuser,  // cmd
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // write_load, load_value, trigger_reload, start_compare, phase_deficit,
  // period_estimate
  output logic [103:0]               m_axis_tdata
);
  import ppstd_pkg::*;

  // Input register
  logic            in_v_q;
  cmd_e            in_cmd_q;
  logic [CntW-1:0] in_cap_q;
  logic            in_cmp_q;

  // Result register
  logic    out_v_q;
  result_t out_q;
  result_t res;

  logic advance;

  assign advance       = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || advance;

  // Accept a word into the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_cmd_q <= cmd_e'(s_axis_tuser);
      in_cap_q <= s_axis_tdata[CntW-1:0];
      in_cmp_q <= s_axis_tdata[CntW];
    end
  end

  ppstd_core #(
    .AVG_LEN (AVG_LEN)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (advance),
    .cmd_i       (in_cmd_q),
    .cap_i       (in_cap_q),
    .cmp_on_i    (in_cmp_q),
    .res_o       (res)
  );

  // Advance the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (!out_v_q || m_axis_tready) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res;
    end
  end

  // Pack the result word
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'b00000,
                          out_q.period_estimate,
                          out_q.phase_deficit,
                          out_q.start_compare,
                          out_q.trigger_reload,
                          out_q.load_value,
                          out_q.write_load};

endmodule
